>>> hdl/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and codes for the first-fit channel allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_HOP  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [5:0]  link_slot;
        logic [7:0]  node_from;
        logic [7:0]  node_to;
        logic [31:0] free_mask;
        logic [15:0] request_id;
        logic        last_hop;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] req_tag;
        logic [7:0]  hop_source;
        logic [7:0]  hop_dest;
        logic [4:0]  channel;
        logic        channel_ok;
        logic        routed;
        logic [4:0]  hop_total;
        logic        final_res;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD,
        ST_ALLOC,
        ST_APPLY,
        ST_EMIT,
        ST_CLOSE
    } back_state_t;

endpackage

>>> hdl/first_fit_channel_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_channel_allocator
// Link table with first-fit, all-or-nothing channel commit per path request.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry either a link load (kind 0) or one hop of a path
//   request (kind 1). A two-entry queue decouples the input from the engine
//   and registers each beat. A load is written to the table as it is
//   popped. A hop is popped, then a registered table scan reads one slot a
//   cycle and stops once a match is registered or the table is exhausted.
//   At the last hop the engine walks the held hops, with a hold step for
//   each matched hop to take its lowest free channel, writes back the
//   working copy unless the request failed, then streams reported beats
//   from the output register, one held hop at a time, and closes the
//   request; final_res marks its last beat.
//   A stalled output holds its beat and the engine waits behind it; the
//   queue keeps taking input until full, then stalls the sender.
//   Reset clears the link valid bits, hop count and blocked flag; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_channel_allocator #(
    parameter int MAX_LINKS    = 64,
    parameter int NUM_CHANNELS = 32,
    parameter int MAX_HOPS     = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ffca_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ffca_pkg::out_beat_t out_data
);
    logic               q_valid;
    logic               q_pop;
    ffca_pkg::in_beat_t q_data;

    // front: buffer incoming beats
    ffca_queue #(.DEPTH_LOG2(1)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (q_data)
    );

    // back: table, matching and commit
    ffca_engine #(
        .MAX_LINKS    (MAX_LINKS),
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_HOPS     (MAX_HOPS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_pop    (q_pop),
        .in_data   (q_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule

>>> hdl/ffca_queue.sv
// ----------------------------------------------------------------------------
// ffca_queue
// Small FIFO between the input front and the allocation engine.
// ----------------------------------------------------------------------------
module ffca_queue #(
    parameter int DEPTH_LOG2 = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ffca_pkg::in_beat_t in_data,
    output logic               out_valid,
    input  logic               out_pop,
    output ffca_pkg::in_beat_t out_data
);
    localparam int DEPTH = 1 << DEPTH_LOG2;

    ffca_pkg::in_beat_t mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_reg, rd_reg;
    logic [DEPTH_LOG2:0]   cnt_reg;
    logic push, pop;

    assign in_stall  = (cnt_reg == (DEPTH_LOG2+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

>>> hdl/ffca_engine.sv
// ----------------------------------------------------------------------------
// ffca_engine
// Link table, hop buffer and first-fit commit sequencer.
// ----------------------------------------------------------------------------
module ffca_engine #(
    parameter int MAX_LINKS    = 64,
    parameter int NUM_CHANNELS = 32,
    parameter int MAX_HOPS     = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_pop,
    input  ffca_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ffca_pkg::out_beat_t out_data
);
    localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int HW = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int NW = $clog2(MAX_HOPS + 1);

    // link table
    logic [MAX_LINKS-1:0]    lvalid_reg;
    logic [7:0]              lsrc_mem  [MAX_LINKS];
    logic [7:0]              ldst_mem  [MAX_LINKS];
    logic [NUM_CHANNELS-1:0] lfree_mem [MAX_LINKS];
    // working copy, valid per link
    logic [NUM_CHANNELS-1:0] wfree_mem [MAX_LINKS];
    logic [MAX_LINKS-1:0]    wvalid_reg;
    // hop buffer
    logic [LW-1:0]  hlink_mem [MAX_HOPS];
    logic [15:0]    hnodes_mem [MAX_HOPS];
    logic           hmatch_mem [MAX_HOPS];
    logic [CW-1:0]  hch_mem    [MAX_HOPS];
    logic           hok_mem    [MAX_HOPS];
    logic [NUM_CHANNELS-1:0] hwork_mem [MAX_HOPS];

    ffca_pkg::back_state_t st_reg, st_next;
    logic [NW-1:0]   held_reg;
    logic            blocked_reg, fail_reg, any_reg;
    logic [LW:0]     scan_reg;
    logic [LW-1:0]   where_reg;
    logic            found_reg;
    logic [NW-1:0]   h_reg;
    logic [NW-1:0]   emit_left_reg;
    logic [15:0]     tag_reg;
    ffca_pkg::in_beat_t cur_reg;
    logic            ovalid_reg;
    ffca_pkg::out_beat_t odata_reg;
    logic [LW-1:0]   l_reg;
    // registered table reads
    logic            rd_live_reg, rd_vld_reg;
    logic [LW-1:0]   rd_idx_reg;
    logic [7:0]      rd_src_reg, rd_dst_reg;
    logic [NUM_CHANNELS-1:0] wf_rd_reg, lf_rd_reg;
    logic            wv_rd_reg;

    logic [LW-1:0] scan_idx;
    logic [HW-1:0] h_idx;
    logic          slot_ok;
    logic [CW-1:0] low_c;
    logic [NUM_CHANNELS-1:0] f_cur;
    logic          out_free;
    logic [4:0]    total;
    logic          scan_more;
    logic          scan_done;
    logic          rd_hit;
    logic          emit_sel;

    assign scan_idx  = scan_reg[LW-1:0];
    assign h_idx     = h_reg[HW-1:0];
    assign slot_ok   = (32'(in_data.link_slot) < 32'(MAX_LINKS));
    assign out_free  = !ovalid_reg || !out_stall;
    assign total     = (32'(held_reg) > 32'd31) ? 5'd31 : 5'(held_reg);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign scan_more = (scan_reg != (LW+1)'(MAX_LINKS));
    assign rd_hit    = rd_live_reg && rd_vld_reg && rd_src_reg == cur_reg.node_from
                       && rd_dst_reg == cur_reg.node_to;
    assign scan_done = found_reg || (!scan_more && !rd_live_reg);
    assign f_cur     = wv_rd_reg ? wf_rd_reg : lf_rd_reg;
    assign emit_sel  = hmatch_mem[h_idx] && (!fail_reg || !hok_mem[h_idx]);

    always_comb
    begin
        low_c = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (f_cur[i])
            begin
                low_c = CW'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ffca_pkg::ST_IDLE:
            begin
                if (in_valid && in_data.kind == ffca_pkg::KIND_HOP)
                begin
                    st_next = (32'(held_reg) < 32'(MAX_HOPS)) ? ffca_pkg::ST_SCAN
                            : (in_data.last_hop ? ffca_pkg::ST_ALLOC : ffca_pkg::ST_IDLE);
                end
            end
            ffca_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    st_next = cur_reg.last_hop ? ffca_pkg::ST_ALLOC : ffca_pkg::ST_IDLE;
                end
            end
            ffca_pkg::ST_ALLOC:
            begin
                if (h_reg == held_reg)
                begin
                    st_next = ffca_pkg::ST_APPLY;
                end
                else if (hmatch_mem[h_idx])
                begin
                    st_next = ffca_pkg::ST_HOLD;
                end
            end
            ffca_pkg::ST_HOLD:
            begin
                st_next = ffca_pkg::ST_ALLOC;
            end
            ffca_pkg::ST_APPLY:
            begin
                if (h_reg == held_reg)
                begin
                    st_next = ffca_pkg::ST_EMIT;
                end
            end
            ffca_pkg::ST_EMIT:
            begin
                if (out_free && h_reg == held_reg)
                begin
                    st_next = ffca_pkg::ST_CLOSE;
                end
            end
            ffca_pkg::ST_CLOSE:
            begin
                if (out_free)
                begin
                    st_next = ffca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = ffca_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_pop = 1'b0;
        if (st_reg == ffca_pkg::ST_IDLE && in_valid)
        begin
            in_pop = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ffca_pkg::ST_IDLE && in_valid)
        begin
            cur_reg <= in_data;
            tag_reg <= in_data.request_id;
            if (in_data.kind == ffca_pkg::KIND_LOAD && slot_ok)
            begin
                lsrc_mem[LW'(in_data.link_slot)]  <= in_data.node_from;
                ldst_mem[LW'(in_data.link_slot)]  <= in_data.node_to;
                lfree_mem[LW'(in_data.link_slot)] <= NUM_CHANNELS'(in_data.free_mask);
            end
        end
        // read one slot a cycle; the compare runs on the registered read, in the cycle after
        if (st_reg == ffca_pkg::ST_SCAN && !scan_done && scan_more)
        begin
            rd_src_reg <= lsrc_mem[scan_idx];
            rd_dst_reg <= ldst_mem[scan_idx];
            rd_vld_reg <= lvalid_reg[scan_idx];
            rd_idx_reg <= scan_idx;
        end
        if (st_reg == ffca_pkg::ST_SCAN && scan_done)
        begin
            hlink_mem[HW'(held_reg)]  <= where_reg;
            hnodes_mem[HW'(held_reg)] <= {cur_reg.node_from, cur_reg.node_to};
            hmatch_mem[HW'(held_reg)] <= found_reg;
        end
        if (st_reg == ffca_pkg::ST_ALLOC && h_reg != held_reg)
        begin
            l_reg     <= hlink_mem[h_idx];
            wf_rd_reg <= wfree_mem[hlink_mem[h_idx]];
            lf_rd_reg <= lfree_mem[hlink_mem[h_idx]];
            wv_rd_reg <= wvalid_reg[hlink_mem[h_idx]];
            hok_mem[h_idx] <= 1'b0;
            hch_mem[h_idx] <= '0;
        end
        if (st_reg == ffca_pkg::ST_HOLD && f_cur != '0)
        begin
            wfree_mem[l_reg] <= f_cur & ~(NUM_CHANNELS'(1) << low_c);
            hwork_mem[h_idx] <= f_cur & ~(NUM_CHANNELS'(1) << low_c);
            hch_mem[h_idx]   <= low_c;
            hok_mem[h_idx]   <= 1'b1;
        end
        // write back one hop a cycle; the last hop on a link leaves its final mask
        if (st_reg == ffca_pkg::ST_APPLY && h_reg != held_reg && !fail_reg
            && hmatch_mem[h_idx])
        begin
            lfree_mem[hlink_mem[h_idx]] <= hwork_mem[h_idx];
        end
        if (out_free)
        begin
            if (st_reg == ffca_pkg::ST_EMIT && h_reg != held_reg)
            begin
                odata_reg.req_tag    <= tag_reg;
                odata_reg.hop_source <= hnodes_mem[h_idx][15:8];
                odata_reg.hop_dest   <= hnodes_mem[h_idx][7:0];
                odata_reg.channel    <= fail_reg ? 5'd0 : 5'(hch_mem[h_idx]);
                odata_reg.channel_ok <= !fail_reg;
                odata_reg.routed     <= !fail_reg;
                odata_reg.hop_total  <= total;
                odata_reg.final_res  <= (emit_left_reg == NW'(1));
            end
            else if (st_reg == ffca_pkg::ST_CLOSE && !any_reg)
            begin
                odata_reg.req_tag    <= tag_reg;
                odata_reg.hop_source <= '0;
                odata_reg.hop_dest   <= '0;
                odata_reg.channel    <= '0;
                odata_reg.channel_ok <= 1'b0;
                odata_reg.routed     <= !fail_reg;
                odata_reg.hop_total  <= total;
                odata_reg.final_res  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ffca_pkg::ST_IDLE;
            lvalid_reg    <= '0;
            wvalid_reg    <= '0;
            held_reg      <= '0;
            blocked_reg   <= 1'b0;
            fail_reg      <= 1'b0;
            any_reg       <= 1'b0;
            scan_reg      <= '0;
            where_reg     <= '0;
            found_reg     <= 1'b0;
            rd_live_reg   <= 1'b0;
            h_reg         <= '0;
            emit_left_reg <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_free && st_reg != ffca_pkg::ST_EMIT && st_reg != ffca_pkg::ST_CLOSE)
            begin
                ovalid_reg <= 1'b0;
            end
            case (st_reg)
                ffca_pkg::ST_IDLE:
                begin
                    scan_reg    <= '0;
                    found_reg   <= 1'b0;
                    where_reg   <= '0;
                    rd_live_reg <= 1'b0;
                    h_reg       <= '0;
                    wvalid_reg  <= '0;
                    fail_reg    <= blocked_reg;
                    if (in_valid && in_data.kind == ffca_pkg::KIND_LOAD && slot_ok)
                    begin
                        lvalid_reg[LW'(in_data.link_slot)] <= 1'b1;
                    end
                    if (in_valid && in_data.kind == ffca_pkg::KIND_HOP
                        && 32'(held_reg) >= 32'(MAX_HOPS))
                    begin
                        blocked_reg <= 1'b1;
                        fail_reg    <= 1'b1;
                    end
                end
                ffca_pkg::ST_SCAN:
                begin
                    if (scan_done)
                    begin
                        held_reg <= held_reg + 1'b1;
                    end
                    else
                    begin
                        rd_live_reg <= scan_more;
                        if (scan_more)
                        begin
                            scan_reg <= scan_reg + 1'b1;
                        end
                        if (rd_hit)
                        begin
                            found_reg <= 1'b1;
                            where_reg <= rd_idx_reg;
                        end
                    end
                end
                ffca_pkg::ST_ALLOC:
                begin
                    if (h_reg == held_reg)
                    begin
                        h_reg         <= '0;
                        any_reg       <= 1'b0;
                        emit_left_reg <= '0;
                    end
                    else if (!hmatch_mem[h_idx])
                    begin
                        h_reg <= h_reg + 1'b1;
                    end
                end
                ffca_pkg::ST_HOLD:
                begin
                    h_reg <= h_reg + 1'b1;
                    if (f_cur == '0)
                    begin
                        fail_reg <= 1'b1;
                    end
                    else
                    begin
                        wvalid_reg[l_reg] <= 1'b1;
                    end
                end
                ffca_pkg::ST_APPLY:
                begin
                    if (h_reg == held_reg)
                    begin
                        h_reg <= '0;
                    end
                    else
                    begin
                        h_reg <= h_reg + 1'b1;
                        if (emit_sel)
                        begin
                            emit_left_reg <= emit_left_reg + 1'b1;
                        end
                    end
                end
                ffca_pkg::ST_EMIT:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b0;
                        if (h_reg != held_reg)
                        begin
                            h_reg <= h_reg + 1'b1;
                            if (emit_sel)
                            begin
                                ovalid_reg    <= 1'b1;
                                any_reg       <= 1'b1;
                                emit_left_reg <= emit_left_reg - 1'b1;
                            end
                        end
                    end
                end
                ffca_pkg::ST_CLOSE:
                begin
                    if (out_free)
                    begin
                        ovalid_reg  <= !any_reg;
                        held_reg    <= '0;
                        blocked_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives link loads and path-request hops into the first-fit channel
// allocator, predicts every result beat from an internal copy of the link
// table, and compares each output beat field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_LINKS = 64;
    localparam int N_HOPS  = 16;
    localparam int SETTLE  = 400;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    ffca_pkg::in_beat_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ffca_pkg::out_beat_t out_data;

    first_fit_channel_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #2 clk = ~clk;

    // Predictor state: link table and the hops held for the open request.
    bit          tbl_valid [N_LINKS];
    logic [7:0]  tbl_src [N_LINKS];
    logic [7:0]  tbl_dst [N_LINKS];
    logic [31:0] tbl_free [N_LINKS];
    logic [5:0]  held_link [N_HOPS];
    logic [7:0]  held_from [N_HOPS];
    logic [7:0]  held_to [N_HOPS];
    bit          held_match [N_HOPS];
    int          held_cnt = 0;
    bit          blocked = 1'b0;

    ffca_pkg::in_beat_t  pending_beats[$];
    ffca_pkg::out_beat_t expected_beats[$];
    int          errors = 0;
    bit          quiet = 1'b0;
    int          pause_at = -1;
    int          sent_cnt = 0;
    int          acc_cnt = 0;
    int          n_items = 0;

    function automatic int lowest_free(logic [31:0] v);
        for (int i = 0; i < 32; i++)
            if (v[i])
                return i;
        return 0;
    endfunction

    function automatic void add_beat(ffca_pkg::in_beat_t b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic void add_expect(ffca_pkg::out_beat_t r);
        expected_beats.insert(expected_beats.size(), r);
    endfunction

    // Apply one accepted beat to the predictor and queue the results it causes.
    task automatic predict_allocation(ffca_pkg::in_beat_t b);
        logic [31:0]         work [N_LINKS];
        logic [4:0]          ch [N_HOPS];
        bit                  ok [N_HOPS];
        bit                  fail;
        int                  cnt;
        int                  c;
        ffca_pkg::out_beat_t r;
        if (b.kind == ffca_pkg::KIND_LOAD)
        begin
            tbl_valid[b.link_slot] = 1'b1;
            tbl_src[b.link_slot]   = b.node_from;
            tbl_dst[b.link_slot]   = b.node_to;
            tbl_free[b.link_slot]  = b.free_mask;
            return;
        end
        if (held_cnt < N_HOPS)
        begin
            held_match[held_cnt] = 1'b0;
            held_link[held_cnt]  = '0;
            for (int j = 0; j < N_LINKS; j++)
                if (tbl_valid[j] && tbl_src[j] == b.node_from && tbl_dst[j] == b.node_to)
                begin
                    held_match[held_cnt] = 1'b1;
                    held_link[held_cnt]  = 6'(j);
                    break;
                end
            held_from[held_cnt] = b.node_from;
            held_to[held_cnt]   = b.node_to;
            held_cnt++;
        end
        else
            blocked = 1'b1;
        if (!b.last_hop)
            return;
        fail = blocked;
        work = tbl_free;
        for (int h = 0; h < held_cnt; h++)
        begin
            ok[h] = 1'b0;
            ch[h] = '0;
            if (!held_match[h])
                continue;
            if (work[held_link[h]] != 0)
            begin
                c = lowest_free(work[held_link[h]]);
                work[held_link[h]][c] = 1'b0;
                ch[h] = 5'(c);
                ok[h] = 1'b1;
            end
            else
                fail = 1'b1;
        end
        if (!fail)
            tbl_free = work;
        cnt = 0;
        r.req_tag   = b.request_id;
        r.hop_total = 5'(held_cnt);
        r.final_res = 1'b0;
        for (int h = 0; h < held_cnt; h++)
        begin
            if (!held_match[h] || (fail && ok[h]))
                continue;
            r.hop_source = held_from[h];
            r.hop_dest   = held_to[h];
            r.channel    = fail ? 5'd0 : ch[h];
            r.channel_ok = !fail;
            r.routed     = !fail;
            add_expect(r);
            cnt++;
        end
        if (cnt == 0)
        begin
            r.hop_source = '0;
            r.hop_dest   = '0;
            r.channel    = '0;
            r.channel_ok = 1'b0;
            r.routed     = !fail;
            add_expect(r);
        end
        expected_beats[$].final_res = 1'b1;
        held_cnt = 0;
        blocked  = 1'b0;
    endtask

    function automatic ffca_pkg::in_beat_t mk_load(int slot, int from, int to,
                                                   logic [31:0] mask);
        ffca_pkg::in_beat_t b;
        b = '0;
        b.kind       = ffca_pkg::KIND_LOAD;
        b.link_slot  = 6'(slot);
        b.node_from  = 8'(from);
        b.node_to    = 8'(to);
        b.free_mask  = mask;
        b.request_id = 16'($urandom);
        b.last_hop   = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic ffca_pkg::in_beat_t mk_hop(int from, int to, bit last,
                                                  logic [15:0] id);
        ffca_pkg::in_beat_t b;
        b = '0;
        b.kind       = ffca_pkg::KIND_HOP;
        b.link_slot  = 6'($urandom);
        b.node_from  = 8'(from);
        b.node_to    = 8'(to);
        b.free_mask  = $urandom;
        b.request_id = id;
        b.last_hop   = last;
        return b;
    endfunction

    // Driver: hold the beat while stalled, advance on acceptance, idle in bursts.
    // At the pause point hold off until every expected beat has drained.
    int in_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_allocation(in_data);
                acc_cnt++;
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0
                         && !(sent_cnt == pause_at && expected_beats.size() != 0))
                begin
                    in_data  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    sent_cnt <= sent_cnt + 1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        in_gap <= $urandom_range(1, 18);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result beat against the oldest prediction.
    int out_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected result beat %p", out_data);
                    errors++;
                end
                else
                begin
                    ffca_pkg::out_beat_t e;
                    e = expected_beats.pop_front();
                    if (out_data.req_tag !== e.req_tag)
                    begin
                        $error("req_tag exp %0d got %0d", e.req_tag, out_data.req_tag);
                        errors++;
                    end
                    if (out_data.hop_source !== e.hop_source)
                    begin
                        $error("hop_source exp %0d got %0d", e.hop_source, out_data.hop_source);
                        errors++;
                    end
                    if (out_data.hop_dest !== e.hop_dest)
                    begin
                        $error("hop_dest exp %0d got %0d", e.hop_dest, out_data.hop_dest);
                        errors++;
                    end
                    if (out_data.channel !== e.channel)
                    begin
                        $error("channel exp %0d got %0d", e.channel, out_data.channel);
                        errors++;
                    end
                    if (out_data.channel_ok !== e.channel_ok)
                    begin
                        $error("channel_ok exp %0d got %0d", e.channel_ok, out_data.channel_ok);
                        errors++;
                    end
                    if (out_data.routed !== e.routed)
                    begin
                        $error("routed exp %0d got %0d", e.routed, out_data.routed);
                        errors++;
                    end
                    if (out_data.hop_total !== e.hop_total)
                    begin
                        $error("hop_total exp %0d got %0d", e.hop_total, out_data.hop_total);
                        errors++;
                    end
                    if (out_data.final_res !== e.final_res)
                    begin
                        $error("final_res exp %0d got %0d", e.final_res, out_data.final_res);
                        errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_gap   <= $urandom_range(0, 17);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Fill the stimulus queue: directed cases, then random requests.
    initial
    begin
        int n_hops;
        int pick;
        int slot;
        logic [15:0] id;

        // Empty table: a lone hop gives only the closing empty beat.
        add_beat(mk_hop(8'hFF, 8'h00, 1, 16'hFFFF));
        // Extreme loads: full mask, single top channel, empty mask, top slot.
        add_beat(mk_load(0, 8'h00, 8'hFF, 32'hFFFF_FFFF));
        add_beat(mk_load(63, 8'hFF, 8'h00, 32'h8000_0000));
        add_beat(mk_load(5, 8'h12, 8'h34, 32'h0));
        // Duplicate link in a higher slot: the lower slot wins.
        add_beat(mk_load(10, 8'h00, 8'hFF, 32'h0000_0001));
        // Repeated link twice plus an unmatched hop; mixed request ids.
        add_beat(mk_hop(8'h00, 8'hFF, 0, 16'h1111));
        add_beat(mk_hop(8'h77, 8'h77, 0, 16'h2222));
        add_beat(mk_hop(8'h00, 8'hFF, 1, 16'h0000));
        // Top channel used twice: the second hop runs out, so it fails.
        add_beat(mk_hop(8'hFF, 8'h00, 0, 16'h0001));
        add_beat(mk_hop(8'hFF, 8'h00, 1, 16'h0002));
        // Link with an empty mask fails alone.
        add_beat(mk_hop(8'h12, 8'h34, 1, 16'hABCD));
        // Too many hops: the request is blocked.
        for (int i = 0; i < 18; i++)
            add_beat(mk_hop(8'h00, 8'hFF, i == 17, 16'h5A5A));

        // Random part: mostly well-formed requests over a small node set.
        for (int i = 0; i < 72; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                slot = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63);
                add_beat(mk_load(slot, $urandom_range(0, 3),
                    $urandom_range(0, 3),
                    $urandom_range(0, 3) == 0 ? $urandom : ($urandom & 32'h0000_0007)));
            end
            else
            begin
                n_hops = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 18)
                                                      : $urandom_range(1, 4);
                id = 16'($urandom);
                for (int h = 0; h < n_hops; h++)
                    add_beat(mk_hop(
                        $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 3),
                        $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 3),
                        h == n_hops - 1,
                        $urandom_range(0, 3) == 0 ? 16'($urandom) : id));
                i += n_hops - 1;
            end
            // Hold off once, at a request boundary, until every expected beat has come.
            if (pause_at < 0 && i >= 40)
                pause_at = pending_beats.size();
        end
        n_items = pending_beats.size();
    end

    initial
    begin
        @(posedge rst_n);
        wait (pending_beats.size() < 30);
        quiet = 1'b1;
        wait (acc_cnt == n_items);
        wait (expected_beats.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && expected_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hold reset low at the start, then release it.
    initial
    begin
        rst_n = 1'b0;
        #32;
        rst_n = 1'b1;
    end

    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
